>>> hdl/cad_pkg.sv
// Shared types and constants for the cartridge address decoder.
package cad_pkg;

	localparam int unsigned ADDR_W = 24;

	typedef enum logic [3:0] {
		TGT_SYSTEM   = 4'd0,
		TGT_UNMAPPED = 4'd1,
		TGT_ROM      = 4'd2,
		TGT_SRAM     = 4'd3,
		TGT_SDD1     = 4'd4,
		TGT_C4       = 4'd5,
		TGT_DSP1     = 4'd6,
		TGT_DSP2     = 4'd7,
		TGT_OBC1     = 4'd8
	} tgt_t;

	typedef enum logic [2:0] {
		REG_MAP_TYPE    = 3'd0,
		REG_ROM_BYTES   = 3'd1,
		REG_SRAM_BYTES  = 3'd2,
		REG_COPROCESSOR = 3'd3,
		REG_DSP_LAYOUT  = 3'd4
	} reg_t;

	typedef enum logic [1:0] {
		MAP_LO   = 2'd0,
		MAP_HI   = 2'd1,
		MAP_EXLO = 2'd2,
		MAP_EXHI = 2'd3
	} map_t;

	typedef enum logic [2:0] {
		COP_NONE = 3'd0,
		COP_SDD1 = 3'd1,
		COP_C4   = 3'd2,
		COP_DSP1 = 3'd3,
		COP_DSP2 = 3'd4,
		COP_OBC1 = 3'd5
	} cop_t;

	typedef enum logic [1:0] {
		DSP_LO1M = 2'd0,
		DSP_LO2M = 2'd1,
		DSP_HI   = 2'd2
	} dsp_t;

	typedef enum logic [1:0] {
		DSEL_NONE = 2'd0,
		DSEL_ROM  = 2'd1,
		DSEL_SRAM = 2'd2
	} dsel_t;

	typedef struct packed {
		logic              valid;
		tgt_t              tgt;
		dsel_t             dsel;
		logic [7:0]        low;
		logic [ADDR_W-1:0] rem;
		logic [ADDR_W-1:0] num;
	} md_t;

endpackage

>>> hdl/cad_rem_pipe.sv
// Pipelined remainder unit: one quotient bit per stage against ROM or SRAM size.
module cad_rem_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [cad_pkg::ADDR_W-1:0] rom_bytes,
	input  logic [cad_pkg::ADDR_W-1:0] sram_bytes,
	input  cad_pkg::md_t               head,
	output cad_pkg::md_t               tail
);

	localparam int unsigned NB = cad_pkg::ADDR_W;

	cad_pkg::md_t md_s [NB];
	cad_pkg::md_t md_in [NB];

	for (genvar k = 0; k < NB; k++) begin : g_bit
		logic [NB-1:0] dvs;
		logic [NB:0]   trial;
		cad_pkg::md_t  nxt;

		if (k == 0) begin : g_first
			assign md_in[k] = head;
		end else begin : g_rest
			assign md_in[k] = md_s[k-1];
		end

		always_comb begin
			unique case (md_in[k].dsel)
				cad_pkg::DSEL_ROM:  dvs = rom_bytes;
				cad_pkg::DSEL_SRAM: dvs = sram_bytes;
				default:            dvs = '0;
			endcase
			trial = {md_in[k].rem, md_in[k].num[NB-1]};
			nxt = md_in[k];
			nxt.num = {md_in[k].num[NB-2:0], 1'b0};
			if (trial >= {1'b0, dvs}) begin
				nxt.rem = NB'(trial - {1'b0, dvs});
			end else begin
				nxt.rem = trial[NB-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				md_s[k] <= '0;
			end else if (en) begin
				md_s[k] <= nxt;
			end
		end
	end

	assign tail = md_s[NB-1];

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(md_s[NB-1]))
		else $error("remainder pipe moved while stalled");

	a_plain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid && tail.dsel == cad_pkg::DSEL_NONE && tail.tgt != cad_pkg::TGT_ROM
		|-> tail.rem == '0)
		else $error("nonzero remainder for a device without offset");

endmodule

>>> hdl/cartridge_address_decoder.sv
// Top level of the cartridge address decoder with its register port and output skid.
// Decodes one 24-bit bus address per cycle while the skid is empty into a target device
// and a byte offset under LoROM, HiROM, ExLoROM or ExHiROM rules with an optional
// coprocessor window on top. Throughput is one address per cycle while the skid is empty.
// The path runs through one decode stage, one stage that folds the address over the two
// ROM chips, 24 remainder stages that each settle one quotient bit against the ROM or SRAM
// size, and the output register. A two-entry output (register plus skid) keeps the input
// open while a result waits. Write the registers only while no beat is in flight.
module cartridge_address_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [23:0] bus_address
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [23:0] offset
	output logic [3:0]  m_axis_tuser   // [3:0] target
);

	localparam int unsigned AW = cad_pkg::ADDR_W;

	typedef struct packed {
		logic              valid;
		cad_pkg::tgt_t     tgt;
		cad_pkg::dsel_t    dsel;
		logic              lohi;
		logic [7:0]        low;
		logic [AW-1:0]     raw;
	} dec_t;

	cad_pkg::map_t map_type_q;
	logic [AW-1:0] rom_bytes_q;
	logic [AW-1:0] sram_bytes_q;
	logic [2:0]    coprocessor_q;
	logic [1:0]    dsp_layout_q;
	logic [AW-1:0] rom_p0_q;
	logic [AW-1:0] rom_mask_q;
	logic [AW-1:0] rom_p1m_q;

	logic          wr_en;
	cad_pkg::reg_t reg_idx;
	logic          en;
	logic [AW-1:0] p0;

	dec_t          dec;
	dec_t          dec_s1;
	cad_pkg::md_t  fold;
	cad_pkg::md_t  fold_s2;
	cad_pkg::md_t  tail;
	logic [AW-1:0] fold_v;

	logic [7:0]    bank;
	logic [6:0]    bk;
	logic [15:0]   lo16;
	logic          low_window;
	logic          cop_hit;
	cad_pkg::tgt_t cop_tgt;

	logic          out_valid_q;
	logic          skid_valid_q;
	cad_pkg::tgt_t out_tgt_q;
	logic [AW-1:0] out_off_q;
	cad_pkg::tgt_t skid_tgt_q;
	logic [AW-1:0] skid_off_q;
	logic [AW-1:0] res_off;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = cad_pkg::reg_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_type_q    <= cad_pkg::MAP_LO;
			rom_bytes_q   <= 24'h100000;
			sram_bytes_q  <= '0;
			coprocessor_q <= cad_pkg::COP_NONE;
			dsp_layout_q  <= cad_pkg::DSP_LO1M;
		end else if (wr_en) begin
			case (reg_idx)
				cad_pkg::REG_MAP_TYPE:    map_type_q    <= cad_pkg::map_t'(pwdata[1:0]);
				cad_pkg::REG_ROM_BYTES:   rom_bytes_q   <= pwdata[AW-1:0];
				cad_pkg::REG_SRAM_BYTES:  sram_bytes_q  <= pwdata[AW-1:0];
				cad_pkg::REG_COPROCESSOR: coprocessor_q <= pwdata[2:0];
				cad_pkg::REG_DSP_LAYOUT:  dsp_layout_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cad_pkg::REG_MAP_TYPE:    prdata = {30'd0, map_type_q};
			cad_pkg::REG_ROM_BYTES:   prdata = {8'd0, rom_bytes_q};
			cad_pkg::REG_SRAM_BYTES:  prdata = {8'd0, sram_bytes_q};
			cad_pkg::REG_COPROCESSOR: prdata = {29'd0, coprocessor_q};
			cad_pkg::REG_DSP_LAYOUT:  prdata = {30'd0, dsp_layout_q};
			default:                  prdata = '0;
		endcase
	end

	// split ROM into a power-of-two chip and a mirrored remainder chip
	always_comb begin
		p0 = '0;
		for (int i = 0; i < AW; i++) begin
			if (rom_bytes_q[i]) begin
				p0 = AW'(1) << i;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_p0_q   <= 24'h100000;
			rom_mask_q <= 24'h0fffff;
			rom_p1m_q  <= 24'hffffff;
		end else begin
			rom_p0_q   <= p0;
			rom_mask_q <= (rom_bytes_q == p0) ? p0 - AW'(1) : p0 + p0 - AW'(1);
			rom_p1m_q  <= rom_bytes_q - p0 - AW'(1);
		end
	end

	// stage 1: decode
	assign en            = !skid_valid_q;
	assign s_axis_tready = en;

	assign bank       = s_axis_tdata[23:16];
	assign bk         = bank[6:0];
	assign lo16       = s_axis_tdata[15:0];
	assign low_window = !bk[6] && lo16[15:13] == 3'b011;

	always_comb begin
		cop_tgt = cad_pkg::TGT_SDD1;
		cop_hit = 1'b0;
		case (coprocessor_q)
			cad_pkg::COP_SDD1: begin
				cop_hit = bank[7:6] == 2'b11;
			end
			cad_pkg::COP_C4: begin
				cop_tgt = cad_pkg::TGT_C4;
				cop_hit = low_window;
			end
			cad_pkg::COP_DSP1: begin
				cop_tgt = cad_pkg::TGT_DSP1;
				cop_hit = (dsp_layout_q == cad_pkg::DSP_LO1M && bk[6:5] == 2'b01 && lo16[15])
					|| (dsp_layout_q == cad_pkg::DSP_LO2M && bk[6:4] == 3'b110 && !lo16[15])
					|| (dsp_layout_q == cad_pkg::DSP_HI && bk[6:5] == 2'b00
						&& lo16[15:13] == 3'b011);
			end
			cad_pkg::COP_DSP2: begin
				cop_tgt = cad_pkg::TGT_DSP2;
				cop_hit = bk[6:5] == 2'b01
					&& (lo16[15:12] == 4'h6 || lo16[15:14] == 2'b10);
			end
			cad_pkg::COP_OBC1: begin
				cop_tgt = cad_pkg::TGT_OBC1;
				cop_hit = low_window;
			end
			default: ;
		endcase
	end

	always_comb begin
		dec.valid = s_axis_tvalid;
		dec.tgt   = cad_pkg::TGT_ROM;
		dec.dsel  = cad_pkg::DSEL_NONE;
		dec.lohi  = 1'b0;
		dec.low   = s_axis_tdata[7:0];
		dec.raw   = '0;
		priority if ((!bk[6] && lo16 < 16'h6000) || bank == 8'h7e || bank == 8'h7f) begin
			dec.tgt = cad_pkg::TGT_SYSTEM;
			dec.low = '0;
		end else if (cop_hit) begin
			dec.tgt = cop_tgt;
			dec.low = '0;
		end else if (bk[6:5] == 2'b00 && lo16[15:13] == 3'b011) begin
			dec.tgt = cad_pkg::TGT_UNMAPPED;
			dec.low = '0;
		end else if (bk[6:5] == 2'b01 && lo16[15:13] == 3'b011) begin
			if (sram_bytes_q == '0) begin
				dec.tgt = cad_pkg::TGT_UNMAPPED;
				dec.low = '0;
			end else begin
				dec.tgt  = cad_pkg::TGT_SRAM;
				dec.dsel = cad_pkg::DSEL_SRAM;
				dec.raw  = {6'd0, bk[4:0], lo16[12:8], 8'h00};
			end
		end else if (bk[6:4] == 3'b111 && !lo16[15]
			&& (map_type_q == cad_pkg::MAP_LO || !bank[7])) begin
			if (sram_bytes_q == '0) begin
				dec.tgt = cad_pkg::TGT_UNMAPPED;
				dec.low = '0;
			end else begin
				dec.tgt  = cad_pkg::TGT_SRAM;
				dec.dsel = cad_pkg::DSEL_SRAM;
				dec.raw  = {5'd0, bk[3:0], lo16[14:8], 8'h00};
			end
		end else if (rom_bytes_q == '0) begin
			dec.tgt = cad_pkg::TGT_UNMAPPED;
			dec.low = '0;
		end else begin
			unique case (map_type_q)
				cad_pkg::MAP_LO: begin
					dec.lohi = 1'b1;
					dec.raw  = {2'd0, bk, lo16[14:8], 8'h00};
				end
				cad_pkg::MAP_HI: begin
					dec.lohi = 1'b1;
					dec.raw  = {s_axis_tdata[23:8], 8'h00};
				end
				cad_pkg::MAP_EXLO: begin
					dec.dsel = cad_pkg::DSEL_ROM;
					if (!bank[6]) begin
						dec.raw = {2'd0, bk, lo16[14:8], 8'h00};
					end else begin
						dec.raw = {2'd0, s_axis_tdata[21:8], 8'h00};
					end
				end
				cad_pkg::MAP_EXHI: begin
					dec.dsel = cad_pkg::DSEL_ROM;
					dec.raw  = {1'b0, !bank[7], s_axis_tdata[21:8], 8'h00};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_s1 <= '0;
		end else if (en) begin
			dec_s1 <= dec;
		end
	end

	// stage 2: fold LoROM and HiROM page over the two chips
	always_comb begin
		fold_v = dec_s1.raw & rom_mask_q;
		fold.valid = dec_s1.valid;
		fold.tgt   = dec_s1.tgt;
		fold.dsel  = dec_s1.dsel;
		fold.low   = dec_s1.low;
		fold.rem   = '0;
		fold.num   = dec_s1.raw;
		if (dec_s1.lohi) begin
			if (fold_v >= rom_p0_q) begin
				fold.num = rom_p0_q + (fold_v & rom_p1m_q);
			end else begin
				fold.num = fold_v;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_s2 <= '0;
		end else if (en) begin
			fold_s2 <= fold;
		end
	end

	cad_rem_pipe u_rem (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.rom_bytes  (rom_bytes_q),
		.sram_bytes (sram_bytes_q),
		.head       (fold_s2),
		.tail       (tail)
	);

	assign res_off = tail.rem + {16'd0, tail.low};

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !m_axis_tready) begin
			if (en && tail.valid) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= en && tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !m_axis_tready) begin
			if (en && tail.valid) begin
				skid_tgt_q <= tail.tgt;
				skid_off_q <= res_off;
			end
		end else if (skid_valid_q) begin
			out_tgt_q <= skid_tgt_q;
			out_off_q <= skid_off_q;
		end else begin
			out_tgt_q <= tail.tgt;
			out_off_q <= res_off;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_off_q;
	assign m_axis_tuser  = out_tgt_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while output is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && m_axis_tready |=> !skid_valid_q)
		else $error("skid not drained after output beat");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_tgt_q != cad_pkg::TGT_ROM && out_tgt_q != cad_pkg::TGT_SRAM
		|-> out_off_q == '0)
		else $error("offset given for a device without storage");

endmodule

>>> bench/tb_cartridge_address_decoder.sv
// Testbench for the cartridge address decoder: stream stimulus, register setups and decode checks.
module tb_cartridge_address_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] COP_IDLE6 = 3'd6;
	localparam logic [2:0] COP_IDLE7 = 3'd7;
	localparam logic [1:0] DSP_IDLE  = 2'd3;

	localparam int NUM_PHASES      = 16;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int DRAIN_CYCLES    = 40;

	typedef struct {
		cad_pkg::tgt_t target;
		logic [23:0]   offset;
	} decode_t;

	typedef struct packed {
		logic [1:0]  map;
		logic [23:0] rom;
		logic [23:0] sram;
		logic [2:0]  cop;
		logic [1:0]  dsp;
	} setup_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE_STALL,
		RX_EVERY_THIRD
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // [23:0] bus_address
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // [23:0] offset
	logic [3:0]  m_axis_tuser;       // [3:0] target

	logic [1:0]  map_mode = cad_pkg::MAP_LO;
	logic [23:0] rom_len = 24'h100000;
	logic [23:0] sram_len = '0;
	logic [2:0]  cop_kind = cad_pkg::COP_NONE;
	logic [1:0]  dsp_window = cad_pkg::DSP_LO1M;

	logic [23:0] address_queue[$];
	decode_t     pending_decodes[$];
	int          error_count = 0;
	logic        hold_off = 1'b0;

	int          gap_left;
	int          burst_left;
	rx_mode_t    ready_mode;
	int          mode_left;

	cartridge_address_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// TGT_SYSTEM marks that no coprocessor window covers the address
	function automatic cad_pkg::tgt_t cop_window(input logic [7:0] bank,
		input logic [15:0] lo16);
		logic [6:0] b;
		logic [7:0] pg;
		logic       low_win;
		b = bank[6:0];
		pg = lo16[15:8];
		low_win = (b <= 7'h3f) && ((lo16 & 16'he000) == 16'h6000);
		case (cop_kind)
			cad_pkg::COP_SDD1:
				return (bank >= 8'hc0) ? cad_pkg::TGT_SDD1 : cad_pkg::TGT_SYSTEM;
			cad_pkg::COP_C4:
				return low_win ? cad_pkg::TGT_C4 : cad_pkg::TGT_SYSTEM;
			cad_pkg::COP_DSP1: begin
				if (dsp_window == cad_pkg::DSP_LO1M && b >= 7'h20 && b <= 7'h3f
				    && lo16 >= 16'h8000)
					return cad_pkg::TGT_DSP1;
				if (dsp_window == cad_pkg::DSP_LO2M && b >= 7'h60 && b <= 7'h6f
				    && lo16 < 16'h8000)
					return cad_pkg::TGT_DSP1;
				if (dsp_window == cad_pkg::DSP_HI && b <= 7'h1f
				    && (lo16 & 16'he000) == 16'h6000)
					return cad_pkg::TGT_DSP1;
				return cad_pkg::TGT_SYSTEM;
			end
			cad_pkg::COP_DSP2: begin
				if (b >= 7'h20 && b <= 7'h3f &&
				    ((pg >= 8'h60 && pg <= 8'h6f) || (pg >= 8'h80 && pg <= 8'hbf)))
					return cad_pkg::TGT_DSP2;
				return cad_pkg::TGT_SYSTEM;
			end
			cad_pkg::COP_OBC1:
				return low_win ? cad_pkg::TGT_OBC1 : cad_pkg::TGT_SYSTEM;
			default:
				return cad_pkg::TGT_SYSTEM;
		endcase
	endfunction

	// rom_len must be nonzero here
	function automatic logic [31:0] rom_page_base(input logic [31:0] page,
		input logic [7:0] bank);
		logic [31:0] a;
		logic [31:0] p0;
		logic [31:0] p1;
		logic [31:0] mask;
		a = page;
		p0 = 32'h800000;
		while ((rom_len & p0) == 0)
			p0 = p0 >> 1;
		p1 = rom_len - p0;
		mask = (rom_len == p0) ? p0 - 1 : p0 + p0 - 1;
		case (map_mode)
			cad_pkg::MAP_LO: begin
				a = {25'd0, bank[6:0]} * 32'h8000 + (a & 32'h7fff);
				a = a & mask;
				if (a >= p0)
					a = p0 + (a & (p1 - 1));
				return a;
			end
			cad_pkg::MAP_HI: begin
				a = a & mask;
				if (a >= p0)
					a = p0 + (a & (p1 - 1));
				return a;
			end
			cad_pkg::MAP_EXLO: begin
				if (!bank[6])
					a = ({25'd0, bank[6:0]} << 15) | (a & 32'h7fff);
				else
					a = a & 32'h3fffff;
				return a % rom_len;
			end
			default: begin
				a = (a & 32'h3fffff) + ((bank < 8'h80) ? 32'h400000 : 32'h0);
				return a % rom_len;
			end
		endcase
	endfunction

	function automatic decode_t decode_address(input logic [23:0] addr);
		decode_t       d;
		logic [7:0]    bank;
		logic [31:0]   b;
		logic [31:0]   lo16;
		logic [31:0]   page;
		logic [31:0]   low;
		logic [31:0]   full;
		cad_pkg::tgt_t win;
		bank = addr[23:16];
		b = {25'd0, bank[6:0]};
		lo16 = {16'd0, addr[15:0]};
		page = {8'd0, addr[23:8], 8'd0};
		low = {24'd0, addr[7:0]};
		full = 0;
		d.target = cad_pkg::TGT_ROM;
		win = cop_window(bank, addr[15:0]);
		if ((b <= 32'h3f && lo16 < 32'h6000) || bank == 8'h7e || bank == 8'h7f) begin
			d.target = cad_pkg::TGT_SYSTEM;
		end else if (win != cad_pkg::TGT_SYSTEM) begin
			d.target = win;
		end else if (b <= 32'h1f && (lo16 & 32'he000) == 32'h6000) begin
			d.target = cad_pkg::TGT_UNMAPPED;
		end else if (b >= 32'h20 && b <= 32'h3f && (lo16 & 32'he000) == 32'h6000) begin
			if (sram_len == 0) begin
				d.target = cad_pkg::TGT_UNMAPPED;
			end else begin
				d.target = cad_pkg::TGT_SRAM;
				full = ((b - 32'h20) * 32'h2000 + ((page & 32'hffff) - 32'h6000)) % sram_len
				       + low;
			end
		end else if (b >= 32'h70 && lo16 < 32'h8000
			&& (map_mode == cad_pkg::MAP_LO || bank < 8'h80)) begin
			if (sram_len == 0) begin
				d.target = cad_pkg::TGT_UNMAPPED;
			end else begin
				d.target = cad_pkg::TGT_SRAM;
				full = ((b - 32'h70) * 32'h8000 + (page & 32'h7fff)) % sram_len + low;
			end
		end else if (rom_len == 0) begin
			d.target = cad_pkg::TGT_UNMAPPED;
		end else begin
			full = rom_page_base(page, bank) + low;
		end
		d.offset = full[23:0];
		return d;
	endfunction

	function automatic logic [23:0] random_size();
		int unsigned r;
		r = $urandom_range(0, 5);
		case (r)
			0: return 24'd1 << $urandom_range(0, 23);
			1: return (24'd1 << $urandom_range(0, 23)) | (24'd1 << $urandom_range(0, 23));
			2: return 24'($urandom_range(1, 24'hffffff));
			3: return 24'hffffff;
			4: return 24'd0;
			default: return 24'($urandom_range(1, 24'h40000));
		endcase
	endfunction

	function automatic logic [23:0] random_address();
		logic [31:0] r;
		logic [7:0]  bank;
		logic [15:0] lo16;
		r = $urandom();
		case ($urandom_range(0, 6))
			0: bank = {r[31], 2'b01, r[4:0]};
			1: bank = {r[31], 1'b0, r[5:0]};
			2: bank = {r[31], 3'b110, r[3:0]};
			3: bank = {r[31], 3'b111, r[3:0]};
			4: bank = {2'b11, r[5:0]};
			default: bank = r[7:0];
		endcase
		r = $urandom();
		case ($urandom_range(0, 5))
			0: lo16 = {3'b011, r[12:0]};
			1: lo16 = {1'b1, r[14:0]};
			2: lo16 = 16'($urandom_range(0, 16'h5fff));
			3: begin
				case (r[18:16])
					3'd0: lo16 = 16'h0000;
					3'd1: lo16 = 16'h5fff;
					3'd2: lo16 = 16'h6000;
					3'd3: lo16 = 16'h7fff;
					3'd4: lo16 = 16'h8000;
					3'd5: lo16 = 16'hbfff;
					3'd6: lo16 = 16'hc000;
					default: lo16 = 16'hffff;
				endcase
			end
			default: lo16 = r[15:0];
		endcase
		return {bank, lo16};
	endfunction

	function automatic setup_t phase_setup(input int phase);
		setup_t s;
		case (phase)
			0: s = '{cad_pkg::MAP_LO, 24'h300000, 24'h002000, cad_pkg::COP_DSP1,
				cad_pkg::DSP_LO1M};
			1: s = '{cad_pkg::MAP_HI, 24'hffffff, 24'hffffff, cad_pkg::COP_SDD1,
				cad_pkg::DSP_LO1M};
			2: s = '{cad_pkg::MAP_EXLO, 24'h000001, 24'h000001, cad_pkg::COP_C4,
				cad_pkg::DSP_LO2M};
			3: s = '{cad_pkg::MAP_EXHI, 24'h600000, 24'h008000, cad_pkg::COP_DSP2,
				cad_pkg::DSP_HI};
			4: s = '{cad_pkg::MAP_LO, 24'h000000, 24'h000000, cad_pkg::COP_OBC1,
				cad_pkg::DSP_LO1M};
			5: s = '{cad_pkg::MAP_HI, 24'h400000, 24'h001234, cad_pkg::COP_DSP1,
				cad_pkg::DSP_LO2M};
			6: s = '{cad_pkg::MAP_LO, 24'h280000, 24'h0007ff, cad_pkg::COP_DSP1,
				cad_pkg::DSP_HI};
			7: s = '{cad_pkg::MAP_EXHI, 24'hffffff, 24'h000000, COP_IDLE6, DSP_IDLE};
			8: s = '{cad_pkg::MAP_EXLO, 24'h800000, 24'h000800, cad_pkg::COP_DSP1,
				DSP_IDLE};
			9: s = '{cad_pkg::MAP_HI, 24'h100000, 24'h020000, COP_IDLE7,
				cad_pkg::DSP_LO1M};
			default: begin
				s.map = 2'($urandom_range(0, 3));
				s.rom = random_size();
				s.sram = random_size();
				s.cop = 3'($urandom_range(0, 7));
				s.dsp = 2'($urandom_range(0, 3));
			end
		endcase
		return s;
	endfunction

	task automatic write_register(input cad_pkg::reg_t index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			cad_pkg::REG_MAP_TYPE:    map_mode = value[1:0];
			cad_pkg::REG_ROM_BYTES:   rom_len = value[23:0];
			cad_pkg::REG_SRAM_BYTES:  sram_len = value[23:0];
			cad_pkg::REG_COPROCESSOR: cop_kind = value[2:0];
			cad_pkg::REG_DSP_LAYOUT:  dsp_window = value[1:0];
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			gap_left = 0;
			burst_left = $urandom_range(1, 48);
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				pending_decodes.push_back(decode_address(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (address_queue.size() != 0) begin
					s_axis_tdata <= address_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		decode_t want;
		logic    rdy;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_mode = RX_OPEN;
			mode_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_decodes.size() == 0) begin
					$error("unexpected beat: tuser %h tdata %h", m_axis_tuser, m_axis_tdata);
					error_count++;
				end else begin
					want = pending_decodes.pop_front();
					if (m_axis_tuser !== want.target) begin
						$error("target: expected %0d, got %0d", want.target, m_axis_tuser);
						error_count++;
					end
					if (m_axis_tdata !== want.offset) begin
						$error("offset: expected %h, got %h", want.offset, m_axis_tdata);
						error_count++;
					end
				end
			end
			if (mode_left == 0) begin
				ready_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 128);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				RX_OPEN:         rdy = 1'b1;
				RX_COIN:         rdy = 1'($urandom_range(0, 1));
				RX_SPARSE_STALL: rdy = $urandom_range(0, 9) != 0;
				default:         rdy = (mode_left % 3) == 0;
			endcase
			m_axis_tready <= rdy && !hold_off;
		end
	end

	// hold the output closed while a backlog is offered, so the input stalls
	initial begin
		repeat (2) begin
			do @(negedge clk); while (address_queue.size() < 60);
			@(posedge clk);
			hold_off <= 1'b1;
			repeat (300) @(posedge clk);
			hold_off <= 1'b0;
			do @(negedge clk); while (address_queue.size() >= 10);
		end
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		setup_t s;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			s = phase_setup(phase);
			write_register(cad_pkg::REG_MAP_TYPE, {30'd0, s.map});
			write_register(cad_pkg::REG_ROM_BYTES, {8'd0, s.rom});
			write_register(cad_pkg::REG_SRAM_BYTES, {8'd0, s.sram});
			write_register(cad_pkg::REG_COPROCESSOR, {29'd0, s.cop});
			write_register(cad_pkg::REG_DSP_LAYOUT, {30'd0, s.dsp});
			@(negedge clk);
			if (phase == 0) begin
				address_queue = '{
					24'h000000, 24'h3f5fff, 24'h7e1234, 24'h7fffff, 24'h006000,
					24'h9f7fff, 24'h206000, 24'h3f7fff, 24'h708000, 24'h700000,
					24'hf00000, 24'hff7fff, 24'h208000, 24'hbfffff, 24'h008000,
					24'h808000, 24'hffffff, 24'h7dffff, 24'h400000, 24'hc00000,
					24'h3fffff, 24'h1fffff, 24'h605000
				};
			end else begin
				repeat (ITEMS_PER_PHASE)
					address_queue.push_back(random_address());
			end
			do @(negedge clk);
			while (address_queue.size() != 0 || s_axis_tvalid || pending_decodes.size() != 0);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
